// File: rtl/aesd_pkg.sv
// Package with the types, tables and functions for AES-128 decryption.
package aesd_pkg;

  localparam int NumRounds = 10;

  typedef logic [7:0] byte_t;
  typedef logic [127:0] blk_t;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CfgKeyHigh = 2'd0;
  localparam cfg_idx_t CfgKeyLow  = 2'd1;

  localparam byte_t InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  localparam byte_t Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [31:0] Rcon [NumRounds] = '{
    32'h01000000, 32'h02000000, 32'h04000000, 32'h08000000, 32'h10000000,
    32'h20000000, 32'h40000000, 32'h80000000, 32'h1b000000, 32'h36000000
  };

  function automatic byte_t xtime(byte_t a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // Next 128-bit round key from the previous one.
  function automatic blk_t next_key(blk_t k, logic [3:0] rnd);
    logic [31:0] t;
    logic [31:0] w0, w1, w2, w3;
    t = {Sbox[k[23:16]], Sbox[k[15:8]], Sbox[k[7:0]], Sbox[k[31:24]]} ^ Rcon[rnd];
    w0 = k[127:96] ^ t;
    w1 = k[95:64] ^ w0;
    w2 = k[63:32] ^ w1;
    w3 = k[31:0] ^ w2;
    return {w0, w1, w2, w3};
  endfunction

  // Byte n sits in bits 127-8n down to 120-8n.
  function automatic blk_t inv_shift_sub(blk_t s);
    blk_t t;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        t[127 - 8 * (4 * c + r) -: 8] = InvSbox[s[127 - 8 * (4 * ((c + 4 - r) % 4) + r) -: 8]];
      end
    end
    return t;
  endfunction

  function automatic blk_t inv_mix(blk_t s);
    blk_t t;
    byte_t a0, a1, a2, a3;
    byte_t x2 [4];
    byte_t x4 [4];
    byte_t x8 [4];
    byte_t m9 [4];
    byte_t mb [4];
    byte_t md [4];
    byte_t me [4];
    for (int c = 0; c < 4; c++) begin
      for (int k = 0; k < 4; k++) begin
        a0 = s[127 - 8 * (4 * c + k) -: 8];
        x2[k] = xtime(a0);
        x4[k] = xtime(x2[k]);
        x8[k] = xtime(x4[k]);
        m9[k] = x8[k] ^ a0;
        mb[k] = x8[k] ^ x2[k] ^ a0;
        md[k] = x8[k] ^ x4[k] ^ a0;
        me[k] = x8[k] ^ x4[k] ^ x2[k];
      end
      a0 = me[0] ^ mb[1] ^ md[2] ^ m9[3];
      a1 = m9[0] ^ me[1] ^ mb[2] ^ md[3];
      a2 = md[0] ^ m9[1] ^ me[2] ^ mb[3];
      a3 = mb[0] ^ md[1] ^ m9[2] ^ me[3];
      t[127 - 32 * c -: 32] = {a0, a1, a2, a3};
    end
    return t;
  endfunction

endpackage

// File: rtl/aesd_cell.sv
// One inverse round stage: shift, substitute, add round key, optional column mix.
module aesd_cell (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           adv,
  input  logic           last,
  input  logic           in_vld,
  input  aesd_pkg::blk_t in_data,
  input  aesd_pkg::blk_t rkey,
  output logic           out_vld,
  output aesd_pkg::blk_t out_data
);

  logic           vld_r;
  aesd_pkg::blk_t data_r;
  aesd_pkg::blk_t data_nxt;
  aesd_pkg::blk_t ark;

  always_comb begin
    ark = aesd_pkg::inv_shift_sub(in_data) ^ rkey;
    data_nxt = last ? ark : aesd_pkg::inv_mix(ark);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      data_r <= data_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_data = data_r;

endmodule

// File: rtl/aes128_block_decrypt.sv
// Top level of the pipelined AES-128 block decryptor.
// Pipelined AES-128 inverse cipher with one stage per inverse round: one 128-bit
// block is accepted per cycle if the pipe moves and no key expansion runs. Each stage
// registers its state and hands it to the next stage each cycle the pipe moves;
// the pipe halts only while the last stage holds a result that is not taken.
// Writing a key register starts a fresh expansion of the round keys into
// flip-flops, one round key per cycle. While that expansion runs, and while
// the expansion after reset runs, neither blocks nor key writes are accepted.
// The block must be idle when a key register is written.
module aes128_block_decrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] in_cipher_high,
  input  logic [63:0] in_cipher_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] out_plain_high,
  output logic [63:0] out_plain_low,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [63:0] cfg_index,
  input  logic [63:0] cfg_data
);

  localparam int N = aesd_pkg::NumRounds;

  logic [63:0]    key_high_r, key_low_r;
  logic           sched_busy_r;
  logic [3:0]     sched_cnt_r;
  aesd_pkg::blk_t key_cur_r;
  aesd_pkg::blk_t sched_key_nxt;
  aesd_pkg::blk_t rk_r [N + 1];
  logic           vld [N + 1];
  aesd_pkg::blk_t dat [N + 1];
  logic           adv;

  assign cfg_ready = !sched_busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r   <= '0;
      key_low_r    <= '0;
      sched_busy_r <= 1'b1;
      sched_cnt_r  <= '0;
    end else if (sched_busy_r) begin
      sched_cnt_r <= sched_cnt_r + 4'd1;
      if (sched_cnt_r == 4'(N)) begin
        sched_busy_r <= 1'b0;
      end
    end else if (cfg_valid && cfg_index == 64'(aesd_pkg::CfgKeyHigh)) begin
      key_high_r   <= cfg_data;
      sched_busy_r <= 1'b1;
      sched_cnt_r  <= '0;
    end else if (cfg_valid && cfg_index == 64'(aesd_pkg::CfgKeyLow)) begin
      key_low_r    <= cfg_data;
      sched_busy_r <= 1'b1;
      sched_cnt_r  <= '0;
    end
  end

  // Round key 0 is the key itself; each later one follows from its predecessor.
  always_comb begin
    if (sched_cnt_r == 4'd0) begin
      sched_key_nxt = {key_high_r, key_low_r};
    end else begin
      sched_key_nxt = aesd_pkg::next_key(key_cur_r, sched_cnt_r - 4'd1);
    end
  end

  always_ff @(posedge clk) begin
    if (sched_busy_r) begin
      rk_r[sched_cnt_r] <= sched_key_nxt;
      key_cur_r         <= sched_key_nxt;
    end
  end

  assign adv      = !vld[N] || out_ready;
  assign in_ready = adv && !sched_busy_r;

  assign vld[0] = in_valid && in_ready;
  assign dat[0] = {in_cipher_high, in_cipher_low} ^ rk_r[N];

  for (genvar g = 0; g < N; g++) begin : g_cell
    aesd_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .last     (g == N - 1),
      .in_vld   (vld[g]),
      .in_data  (dat[g]),
      .rkey     (rk_r[N - 1 - g]),
      .out_vld  (vld[g + 1]),
      .out_data (dat[g + 1])
    );
  end

  assign out_valid      = vld[N];
  assign out_plain_high = dat[N][127:64];
  assign out_plain_low  = dat[N][63:0];

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_plain_high))
    else $error("result changed while stalled");
  a_noacc_upd: assert property (@(posedge clk) disable iff (!rst_n)
    sched_busy_r |-> !in_ready)
    else $error("input taken during schedule update");
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while pipe is stalled");

endmodule
